// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

	// Fixed port widths
	localparam int unsigned ACTION_BITS = 2;
	localparam int unsigned FIELD_BITS  = 16;
	localparam int unsigned HANDLE_BITS = 16;
	localparam int unsigned STATUS_BITS = 2;
	localparam int unsigned OCC_BITS    = 7;

	// Defaults for the top-level parameters
	localparam int unsigned DEF_DEPTH    = 64;
	localparam int unsigned DEF_KEY_BITS = 16;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_INSERT    = 2'd0,
		ACT_POP_FIRST = 2'd1,
		ACT_POP_LAST  = 2'd2,
		ACT_REMOVE    = 2'd3
	} action_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LAST,
		S_FIND
	} state_t;

	// Command broadcast from the controller to every cell
	typedef struct packed {
		logic ins;   // sorted insert of the incoming entry
		logic pop;   // shift everything one cell toward the head
		logic mark;  // flag the last occupied cell as victim
		logic seed;  // launch a handle search token at the head
	} cell_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// One queue cell: holds one entry and trades it with its neighbors.
`default_nettype none

module spq_cell #(
	parameter int unsigned KEY_BITS = spq_pkg::DEF_KEY_BITS,
	parameter bit          IS_HEAD  = 1'b0
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire spq_pkg::cell_cmd_t             cmd,
	input  wire logic [KEY_BITS-1:0]            ins_key,
	input  wire logic [spq_pkg::HANDLE_BITS-1:0] ins_handle,
	input  wire logic [spq_pkg::HANDLE_BITS-1:0] find_handle,
	input  wire logic                           occ,
	input  wire logic                           occ_right,
	input  wire logic                           take_left,
	input  wire logic [KEY_BITS-1:0]            key_left,
	input  wire logic [spq_pkg::HANDLE_BITS-1:0] handle_left,
	input  wire logic                           tok_left,
	input  wire logic [KEY_BITS-1:0]            key_right,
	input  wire logic [spq_pkg::HANDLE_BITS-1:0] handle_right,
	input  wire logic                           kill_right,
	output logic                                take_here,
	output logic                                tok_pass,
	output logic                                kill_flag,
	output logic [KEY_BITS-1:0]                 cur_key,
	output logic [spq_pkg::HANDLE_BITS-1:0]     cur_handle
);
	import spq_pkg::*;

	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   kill_q;
	logic                   tok_q;
	logic                   match;

	// Local compares: insert boundary and handle hit
	always_comb begin
		match     = occ && (handle_q == find_handle);
		take_here = !occ || (ins_key <= key_q);
		tok_pass  = tok_q && !match;
	end

	assign kill_flag  = kill_q;
	assign cur_key    = key_q;
	assign cur_handle = handle_q;

	// Entry data: insert shifts right, pop shifts left, victim swaps toward head
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (take_left) begin
				key_q    <= key_left;
				handle_q <= handle_left;
			end else if (take_here) begin
				key_q    <= ins_key;
				handle_q <= ins_handle;
			end
		end else if (cmd.pop || kill_right) begin
			key_q    <= key_right;
			handle_q <= handle_right;
		end else if (kill_q && !IS_HEAD) begin
			key_q    <= key_left;
			handle_q <= handle_left;
		end
	end

	// Victim flag and search token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kill_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			if (cmd.ins) begin
				kill_q <= 1'b0;
			end else if (cmd.pop) begin
				kill_q <= kill_right;
			end else if (cmd.mark) begin
				kill_q <= occ && !occ_right;
			end else begin
				kill_q <= kill_right || (kill_q && IS_HEAD) || (tok_q && match);
			end
			if (cmd.ins || cmd.pop || cmd.mark) begin
				tok_q <= 1'b0;
			end else begin
				tok_q <= tok_left && occ;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain plus controller.
//
//  channel | signals                              | role
//  --------+--------------------------------------+----------------------------
//  item    | item_valid item_ready action key      | operation request beat
//          | handle                               |
//  result  | result_valid result_ready out_handle | one result beat per request
//          | out_key status occupancy             |
//
// Insert and pop smallest each update every cell of the chain in parallel.
// Pop largest flags the last entry and swaps it toward the head one cell per
// cycle. Remove sends a token down the chain and the hit back up, both by
// neighbor-to-neighbor hops.
// Reset empties the queue at once; entry storage is not cleared.
// A new beat is taken only when the controller is idle and the result register
// is empty or draining; a stalled result holds the controller.
`default_nettype none

module sorted_priority_queue #(
	parameter int unsigned DEPTH    = spq_pkg::DEF_DEPTH,
	parameter int unsigned KEY_BITS = spq_pkg::DEF_KEY_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire logic [spq_pkg::ACTION_BITS-1:0] action,
	input  wire logic [spq_pkg::FIELD_BITS-1:0]  key,
	input  wire logic [spq_pkg::HANDLE_BITS-1:0] handle,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output logic [spq_pkg::HANDLE_BITS-1:0]      out_handle,
	output logic [spq_pkg::FIELD_BITS-1:0]       out_key,
	output logic [spq_pkg::STATUS_BITS-1:0]      status,
	output logic [spq_pkg::OCC_BITS-1:0]         occupancy
);
	import spq_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = $clog2(2 * DEPTH + 1);

	// Chain wiring
	cell_cmd_t              cmd;
	logic [KEY_BITS-1:0]    ins_key;
	logic [HANDLE_BITS-1:0] find_q;
	logic [DEPTH-1:0]       occ, take, tok, kill;
	logic [KEY_BITS-1:0]    ckey [DEPTH];
	logic [HANDLE_BITS-1:0] chnd [DEPTH];

	// Controller state
	state_t                 state_q, state_nxt;
	logic [CW-1:0]          count_q, count_nxt;
	logic [SW-1:0]          step_q, step_nxt;
	logic                   out_valid_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [FIELD_BITS-1:0]  out_key_q;
	status_t                status_q;
	logic [OCC_BITS-1:0]    occ_out_q;

	logic                   out_free, accept, load, take_head;
	status_t                ld_status;
	logic [SW-1:0]          bound;

	assign ins_key = KEY_BITS'(key);

	// Occupied cells form a prefix of the chain
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                   n_occ_r, n_take_l, n_tok_l, n_kill_r;
			logic [KEY_BITS-1:0]    n_key_l, n_key_r;
			logic [HANDLE_BITS-1:0] n_hnd_l, n_hnd_r;

			assign occ[gi] = CW'(gi) < count_q;

			if (gi == 0) begin : g_head
				assign n_take_l = 1'b0;
				assign n_tok_l  = cmd.seed;
				assign n_key_l  = '0;
				assign n_hnd_l  = '0;
			end else begin : g_body
				assign n_take_l = take[gi-1];
				assign n_tok_l  = tok[gi-1];
				assign n_key_l  = ckey[gi-1];
				assign n_hnd_l  = chnd[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign n_occ_r  = 1'b0;
				assign n_kill_r = 1'b0;
				assign n_key_r  = '0;
				assign n_hnd_r  = '0;
			end else begin : g_mid
				assign n_occ_r  = occ[gi+1];
				assign n_kill_r = kill[gi+1];
				assign n_key_r  = ckey[gi+1];
				assign n_hnd_r  = chnd[gi+1];
			end

			spq_cell #(
				.KEY_BITS (KEY_BITS),
				.IS_HEAD  (gi == 0)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.cmd          (cmd),
				.ins_key      (ins_key),
				.ins_handle   (handle),
				.find_handle  (find_q),
				.occ          (occ[gi]),
				.occ_right    (n_occ_r),
				.take_left    (n_take_l),
				.key_left     (n_key_l),
				.handle_left  (n_hnd_l),
				.tok_left     (n_tok_l),
				.key_right    (n_key_r),
				.handle_right (n_hnd_r),
				.kill_right   (n_kill_r),
				.take_here    (take[gi]),
				.tok_pass     (tok[gi]),
				.kill_flag    (kill[gi]),
				.cur_key      (ckey[gi]),
				.cur_handle   (chnd[gi])
			);
		end
	endgenerate

	assign out_free   = !out_valid_q || result_ready;
	assign item_ready = (state_q == S_IDLE) && out_free;
	assign accept     = item_valid && item_ready;
	assign bound      = SW'({count_q, 1'b0});

	// Next state, chain command and result load
	always_comb begin
		state_nxt = state_q;
		count_nxt = count_q;
		step_nxt  = step_q;
		cmd       = '0;
		load      = 1'b0;
		take_head = 1'b0;
		ld_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action_t'(action))
						ACT_INSERT: begin
							load = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								ld_status = ST_FULL;
							end else begin
								cmd.ins   = 1'b1;
								count_nxt = count_q + CW'(1);
							end
						end
						ACT_POP_FIRST: begin
							load = 1'b1;
							if (count_q == '0) begin
								ld_status = ST_EMPTY;
							end else begin
								cmd.pop   = 1'b1;
								take_head = 1'b1;
								count_nxt = count_q - CW'(1);
							end
						end
						ACT_POP_LAST: begin
							if (count_q == '0) begin
								load      = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								cmd.mark  = 1'b1;
								state_nxt = S_LAST;
							end
						end
						ACT_REMOVE: begin
							if (count_q == '0) begin
								load      = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								cmd.seed  = 1'b1;
								step_nxt  = '0;
								state_nxt = S_FIND;
							end
						end
						default: begin
							load = 1'b0;
						end
					endcase
				end
			end
			S_LAST, S_FIND: begin
				if (kill[0]) begin
					// victim has reached the head
					if (out_free) begin
						load      = 1'b1;
						cmd.pop   = 1'b1;
						take_head = 1'b1;
						count_nxt = count_q - CW'(1);
						state_nxt = S_IDLE;
					end
				end else if (state_q == S_FIND) begin
					if (step_q == bound) begin
						// token ran past the last entry without a hit
						if (out_free) begin
							load      = 1'b1;
							ld_status = ST_NOTFOUND;
							state_nxt = S_IDLE;
						end
					end else begin
						step_nxt = step_q + SW'(1);
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Controller registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			step_q  <= step_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search handle and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			find_q <= handle;
		end
		if (load) begin
			status_q  <= ld_status;
			occ_out_q <= OCC_BITS'(count_nxt);
			if (take_head) begin
				out_key_q    <= FIELD_BITS'(ckey[0]);
				out_handle_q <= chnd[0];
			end else begin
				out_key_q    <= '0;
				out_handle_q <= '0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign out_handle   = out_handle_q;
	assign out_key      = out_key_q;
	assign status       = status_q;
	assign occupancy    = occ_out_q;

endmodule

`default_nettype wire

// ===== tb/sorted_priority_queue_test.sv =====
// Self-checking testbench of the sorted priority queue with a queue-based predictor.
`timescale 1ns / 100ps

module sorted_priority_queue_test;
	import spq_pkg::*;

	localparam int unsigned DEPTH    = DEF_DEPTH;
	localparam int unsigned KEY_BITS = DEF_KEY_BITS;
	localparam logic [63:0] KEY_MASK_WIDE = (64'd1 << KEY_BITS) - 64'd1;
	localparam logic [FIELD_BITS-1:0] KEY_MASK = KEY_MASK_WIDE[FIELD_BITS-1:0];

	// Longest receiver hold-off, quiet-cycle watchdog and settle time at the end
	localparam int HOLD_CYCLES    = 250;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 2 * DEPTH + 40;

	typedef struct packed {
		logic [FIELD_BITS-1:0]  key;
		logic [HANDLE_BITS-1:0] handle;
	} open_entry_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] out_handle;
		logic [FIELD_BITS-1:0]  out_key;
		status_t                status;
		logic [OCC_BITS-1:0]    occupancy;
	} queue_result_t;

	// DUT ports; the driven inputs are known from time zero
	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_ready;
	logic [ACTION_BITS-1:0] action       = ACT_INSERT;
	logic [FIELD_BITS-1:0]  key          = '0;
	logic [HANDLE_BITS-1:0] handle       = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	logic [HANDLE_BITS-1:0] out_handle;
	logic [FIELD_BITS-1:0]  out_key;
	logic [STATUS_BITS-1:0] status;
	logic [OCC_BITS-1:0]    occupancy;

	// Predictor state and pending expectations
	open_entry_t   open_list[$];
	queue_result_t expected_results[$];

	int fail_count    = 0;
	int quiet_cycles  = 0;
	int send_run_left = 0;
	bit idle_off      = 1'b0;
	bit hold_pending  = 1'b0;

	sorted_priority_queue #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.key          (key),
		.handle       (handle),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_handle   (out_handle),
		.out_key      (out_key),
		.status       (status),
		.occupancy    (occupancy)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Next queue outcome for one accepted request; updates the open list
	function automatic queue_result_t predict_outcome(input action_t act,
			input logic [FIELD_BITS-1:0] k, input logic [HANDLE_BITS-1:0] h);
		queue_result_t r;
		open_entry_t   ent;
		int            pos;
		int            n;
		r.out_handle = '0;
		r.out_key    = '0;
		r.status     = ST_OK;
		ent.key      = k & KEY_MASK;
		ent.handle   = h;
		if (act == ACT_INSERT) begin
			if (open_list.size() >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// new entry goes ahead of the first key that is not smaller
				pos = -1;
				for (int i = 0; i < open_list.size(); i++)
					if (pos < 0 && ent.key <= open_list[i].key) pos = i;
				if (pos < 0) pos = open_list.size();
				open_list.insert(pos, ent);
			end
		end else if (open_list.size() == 0) begin
			r.status = ST_EMPTY;
		end else if (act == ACT_POP_FIRST) begin
			ent = open_list.pop_front();
			r.out_key    = ent.key;
			r.out_handle = ent.handle;
		end else if (act == ACT_POP_LAST) begin
			ent = open_list.pop_back();
			r.out_key    = ent.key;
			r.out_handle = ent.handle;
		end else begin
			// first match from the head wins
			pos = -1;
			for (int i = 0; i < open_list.size(); i++)
				if (pos < 0 && open_list[i].handle == h) pos = i;
			if (pos < 0) begin
				r.status = ST_NOTFOUND;
			end else begin
				r.out_key    = open_list[pos].key;
				r.out_handle = open_list[pos].handle;
				open_list.delete(pos);
			end
		end
		n = open_list.size();
		r.occupancy = n[OCC_BITS-1:0];
		return r;
	endfunction

	// Offer one request beat, with an optional idle burst ahead of it
	task automatic send_beat(input action_t act, input logic [FIELD_BITS-1:0] k,
			input logic [HANDLE_BITS-1:0] h);
		int gap;
		gap = 0;
		if (!idle_off) begin
			if (send_run_left > 0) send_run_left--;
			else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
			else send_run_left = $urandom_range(1, 30);
		end
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action     <= act;
		key        <= k;
		handle     <= h;
		do @(posedge clk); while (!item_ready);
		expected_results.push_back(predict_outcome(act, k, h));
	endtask

	// Stop offering and wait for every outstanding result beat
	task automatic wait_for_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	function automatic logic [FIELD_BITS-1:0] rand_key();
		case ($urandom_range(0, 3))
			0, 1:    return FIELD_BITS'($urandom_range(0, 15));
			2:       return FIELD_BITS'($urandom_range(0, 16'hFFFF));
			default: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
		endcase
	endfunction

	function automatic logic [HANDLE_BITS-1:0] rand_handle();
		if ($urandom_range(0, 1) == 0) return HANDLE_BITS'($urandom_range(0, 31));
		return HANDLE_BITS'($urandom_range(0, 16'hFFFF));
	endfunction

	// Random requests; insert_pct sets the share of inserts
	task automatic run_random_ops(input int count, input int insert_pct);
		action_t                act;
		logic [HANDLE_BITS-1:0] h;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < insert_pct) begin
				act = ACT_INSERT;
			end else begin
				case ($urandom_range(0, 2))
					0:       act = ACT_POP_FIRST;
					1:       act = ACT_POP_LAST;
					default: act = ACT_REMOVE;
				endcase
			end
			h = rand_handle();
			// removes mostly aim at a handle that is held
			if (act == ACT_REMOVE && open_list.size() > 0 && $urandom_range(0, 3) != 0)
				h = open_list[$urandom_range(0, open_list.size() - 1)].handle;
			send_beat(act, rand_key(), h);
		end
	endtask

	task automatic test_empty_queue();
		send_beat(ACT_POP_FIRST, 16'hFFFF, 16'hFFFF);
		send_beat(ACT_POP_LAST, 16'h0000, 16'h0000);
		send_beat(ACT_REMOVE, 16'h5A5A, 16'h1234);
	endtask

	task automatic test_insert_extremes();
		send_beat(ACT_INSERT, 16'hFFFF, 16'hFFFF);
		send_beat(ACT_INSERT, 16'h0000, 16'h0000);
		send_beat(ACT_INSERT, 16'h8000, 16'h0001);
		send_beat(ACT_POP_FIRST, 16'h0000, 16'h0000);
		send_beat(ACT_POP_LAST, 16'h0000, 16'h0000);
		send_beat(ACT_POP_LAST, 16'h0000, 16'h0000);
	endtask

	// Equal keys put the newest first; duplicate handles remove the first match
	task automatic test_equal_keys();
		send_beat(ACT_INSERT, 16'h0005, 16'h000A);
		send_beat(ACT_INSERT, 16'h0005, 16'h000B);
		send_beat(ACT_INSERT, 16'h0005, 16'h000A);
		send_beat(ACT_REMOVE, 16'h0000, 16'h000A);
		send_beat(ACT_REMOVE, 16'h0000, 16'h7777);
		send_beat(ACT_POP_FIRST, 16'h0000, 16'h0000);
		send_beat(ACT_POP_FIRST, 16'h0000, 16'h0000);
	endtask

	task automatic test_remove_positions();
		send_beat(ACT_INSERT, 16'h0001, 16'h0001);
		send_beat(ACT_INSERT, 16'h0002, 16'h0002);
		send_beat(ACT_INSERT, 16'h0003, 16'h0003);
		send_beat(ACT_REMOVE, 16'h0000, 16'h0003);
		send_beat(ACT_REMOVE, 16'h0000, 16'h0001);
		send_beat(ACT_REMOVE, 16'h0000, 16'h0002);
	endtask

	task automatic test_random_mix();
		run_random_ops(350, 50);
	endtask

	// Insert-heavy run reaches full and rejected inserts, then drain to empty
	task automatic test_fill_and_drain();
		run_random_ops(160, 90);
		run_random_ops(160, 10);
	endtask

	// Receiver holds off while requests keep coming, then sender pauses
	task automatic test_backpressure();
		hold_pending = 1'b1;
		idle_off     = 1'b1;
		run_random_ops(16, 70);
		idle_off     = 1'b0;
		wait_for_results();
	endtask

	task automatic test_steady_stream();
		idle_off = 1'b1;
		run_random_ops(300, 55);
	endtask

	task automatic check_field(input string name, input logic [FIELD_BITS-1:0] want,
			input logic [FIELD_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	// Result beat checker
	always @(posedge clk) begin
		queue_result_t exp_res;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$error("result beat with no request outstanding");
				fail_count++;
			end else begin
				exp_res = expected_results.pop_front();
				check_field("out_handle", exp_res.out_handle, out_handle);
				check_field("out_key", exp_res.out_key, out_key);
				check_field("status", 16'(exp_res.status), 16'(status));
				check_field("occupancy", 16'(exp_res.occupancy), 16'(occupancy));
			end
		end
	end

	// result_ready: random runs and stall bursts, plus the long hold-off
	initial begin : drive_result_ready
		int run_left;
		int stall_left;
		run_left   = 0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				stall_left   = HOLD_CYCLES;
			end else if (stall_left == 0 && run_left == 0 && !idle_off) begin
				if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 19);
				else run_left = $urandom_range(1, 40);
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				if (run_left > 0) run_left--;
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : run_regression
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_insert_extremes();
		test_equal_keys();
		test_remove_positions();
		test_random_mix();
		test_fill_and_drain();
		test_backpressure();
		test_steady_stream();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
